// ===== rtl/rmds_pkg.sv =====
// ----------------------------------------------------------------------------
// rmds_pkg
// Shared widths, stage counts and the payload type of the divider pipeline.
// ----------------------------------------------------------------------------
package rmds_pkg;

   localparam int WORD_BITS      = 32;
   localparam int DIV_STAGES     = 8;
   localparam int BITS_PER_STAGE = WORD_BITS / DIV_STAGES;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type remainder;
      word_type dividend_quotient;
      word_type divisor;
      logic     saturated;
   } div_type;

endpackage

// ===== rtl/rmds_if.sv =====
// ----------------------------------------------------------------------------
// rmds_if
// Request and response channels of the rounded multiply-divide block.
// ----------------------------------------------------------------------------
interface rmds_req_if;
   logic                valid;
   logic                ready;
   rmds_pkg::word_type  multiplicand;
   rmds_pkg::word_type  factor_b;
   rmds_pkg::word_type  divisor;

   modport source (output valid, output multiplicand, output factor_b,
                   output divisor, input ready);
   modport sink   (input valid, input multiplicand, input factor_b,
                   input divisor, output ready);
endinterface

interface rmds_rsp_if;
   logic                valid;
   logic                ready;
   rmds_pkg::word_type  quotient;
   logic                saturated;

   modport source (output valid, output quotient, output saturated,
                   input ready);
   modport sink   (input valid, input quotient, input saturated,
                   output ready);
endinterface

// ===== rtl/rmds_front.sv =====
// ----------------------------------------------------------------------------
// rmds_front
// Two stages: the full product, then the rounding add and overflow check.
// ----------------------------------------------------------------------------
module rmds_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  rmds_pkg::word_type  multiplicand,
   input  rmds_pkg::word_type  factor_b,
   input  rmds_pkg::word_type  divisor,
   output logic                out_valid,
   input  logic                out_ready,
   output rmds_pkg::div_type   out_data
);

   localparam int W = rmds_pkg::WORD_BITS;

   logic                  prod_valid_ff;
   logic [2*W-1:0]        product_ff;
   logic [2*W-1:0]        product_in;
   rmds_pkg::word_type    divisor_ff;
   logic                  sum_valid_ff;
   rmds_pkg::div_type     sum_ff;
   rmds_pkg::div_type     sum_in;
   logic                  prod_ready;
   logic                  sum_ready;
   logic [2*W-1:0]        sum;
   logic                  divisor_zero;

   assign sum_ready  = !sum_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || sum_ready;
   assign in_ready   = prod_ready;

   assign product_in = {{W{1'b0}}, multiplicand} * {{W{1'b0}}, factor_b};

   assign divisor_zero = (divisor_ff == '0);
   assign sum          = product_ff + {{(W+1){1'b0}}, divisor_ff[W-1:1]};

   always_comb begin
      sum_in.remainder         = sum[2*W-1:W];
      sum_in.dividend_quotient = sum[W-1:0];
      if (divisor_zero) begin
         // A zero divisor divides by one, so a zero product gives zero.
         sum_in.divisor   = rmds_pkg::word_type'(1);
         sum_in.saturated = (product_ff != '0);
      end else begin
         sum_in.divisor   = divisor_ff;
         sum_in.saturated = (sum[2*W-1:W] >= divisor_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && in_valid) begin
         product_ff <= product_in;
         divisor_ff <= divisor;
      end
      if (sum_ready && prod_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

endmodule

// ===== rtl/rmds_div_stage.sv =====
// ----------------------------------------------------------------------------
// rmds_div_stage
// One register stage of the restoring divider, resolving a few quotient bits.
// ----------------------------------------------------------------------------
module rmds_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rmds_pkg::div_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rmds_pkg::div_type  out_data
);

   localparam int W = rmds_pkg::WORD_BITS;

   logic               valid_ff;
   rmds_pkg::div_type  data_ff;
   rmds_pkg::div_type  data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      logic [W:0] trial;
      logic [W:0] diff;
      logic       fits;
      data_in = in_data;
      for (int i = 0; i < rmds_pkg::BITS_PER_STAGE; i++) begin
         trial = {data_in.remainder, data_in.dividend_quotient[W-1]};
         diff  = trial - {1'b0, data_in.divisor};
         fits  = (trial >= {1'b0, data_in.divisor});
         data_in.dividend_quotient = {data_in.dividend_quotient[W-2:0], fits};
         data_in.remainder         = fits ? diff[W-1:0] : trial[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/rounded_muldiv_saturating.sv =====
// ----------------------------------------------------------------------------
// rounded_muldiv_saturating
// Each request passes through one multiply stage, one rounding stage and eight
// divider stages of four bits before its response can transfer.
// Throughput: one transfer per cycle; a stall holds every stage in place and
// empty stages still fill. Synchronous reset empties the whole pipeline.
// ----------------------------------------------------------------------------
module rounded_muldiv_saturating (
   input  logic   clock,
   input  logic   reset,
   rmds_req_if.sink   req,
   rmds_rsp_if.source rsp
);

   localparam int N = rmds_pkg::DIV_STAGES;

   logic               stage_valid [N+1];
   logic               stage_ready [N+1];
   rmds_pkg::div_type  stage_data  [N+1];

   rmds_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .multiplicand (req.multiplicand),
      .factor_b     (req.factor_b),
      .divisor      (req.divisor),
      .out_valid    (stage_valid[0]),
      .out_ready    (stage_ready[0]),
      .out_data     (stage_data[0])
   );

   for (genvar s = 0; s < N; s++) begin : g_div
      rmds_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_data   (stage_data[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_data  (stage_data[s+1])
      );
   end

   assign stage_ready[N] = rsp.ready;
   assign rsp.valid      = stage_valid[N];
   assign rsp.saturated  = stage_data[N].saturated;
   assign rsp.quotient   = stage_data[N].saturated ? '1 : stage_data[N].dividend_quotient;

endmodule

// ===== rtl/rmds_checker.sv =====
// ----------------------------------------------------------------------------
// rmds_checker
// Port-level checks of the rounded multiply-divide block.
// ----------------------------------------------------------------------------
module rmds_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rmds_pkg::word_type  rsp_quotient,
   input logic                rsp_saturated
);

   // A saturated result always carries an all-ones quotient.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_quotient == '1)
      else $error("saturated result without all-ones quotient");

   // A waiting result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quotient)
         && $stable(rsp_saturated))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // When the response side takes data, every stage moves and a request fits.
   assert property (@(posedge clock)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // The first cycle after reset shows no response.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response appeared too early after reset");

endmodule

bind rounded_muldiv_saturating rmds_checker u_rmds_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_quotient  (rsp.quotient),
   .rsp_saturated (rsp.saturated)
);

// ===== sim/rounded_muldiv_saturating_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_muldiv_saturating_tb
// Self-checking bench for the rounded multiply-divide block. A short table
// covers zero divisors, saturation and exact all-ones quotients. Random
// operand sets follow, under changing idle rates and a long response stall.
// Every response transfer is compared with a predicted quotient and flag.
// ----------------------------------------------------------------------------
module rounded_muldiv_saturating_tb;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int REPORT_LIMIT  = 10;
   localparam rmds_pkg::word_type ALL_ONES = '1;

   typedef struct packed {
      rmds_pkg::word_type quotient;
      logic               saturated;
   } result_type;

   typedef struct packed {
      rmds_pkg::word_type multiplicand;
      rmds_pkg::word_type factor_b;
      rmds_pkg::word_type divisor;
      logic               typed;
      result_type         result;
   } directed_row_type;

   typedef enum int {
      KIND_ZERO_DIVISOR,
      KIND_SMALL,
      KIND_NEAR_OVERFLOW,
      KIND_TINY_DIVISOR,
      KIND_ROUNDING,
      KIND_FULL_RANGE
   } operand_kind_type;

   localparam int DIRECTED_ROWS = 22;

   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1, '{32'h0000_0001, 1'b0}},
      '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0002, 1'b1, '{32'h0000_0001, 1'b0}},
      '{32'h0000_0001, 32'h0000_0001, 32'h0000_0003, 1'b1, '{32'h0000_0000, 1'b0}},
      '{32'h0000_0003, 32'h0000_0001, 32'h0000_0002, 1'b1, '{32'h0000_0002, 1'b0}},
      '{32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{32'h8000_0000, 32'h0000_0002, 32'h0000_0001, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
      '{32'h0001_0000, 32'h0001_0000, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0002, 1'b0, '{32'h0000_0000, 1'b0}},
      '{32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0003, 1'b0, '{32'h0000_0000, 1'b0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '{32'h0000_0000, 1'b0}},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h1357_9BDF, 1'b0, '{32'h0000_0000, 1'b0}},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0003, 1'b0, '{32'h0000_0000, 1'b0}}
   };

   logic clock;
   logic reset;

   rmds_req_if req ();
   rmds_rsp_if rsp ();

   rounded_muldiv_saturating DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   result_type  expected_results [$];
   logic        row_typed;
   result_type  row_result;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_off_cycles;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   function automatic result_type rounded_quotient(rmds_pkg::word_type a,
                                                   rmds_pkg::word_type b,
                                                   rmds_pkg::word_type d);
      logic [63:0] sum;
      result_type  res;
      res.quotient  = ALL_ONES;
      res.saturated = 1'b1;
      if (d != '0) begin
         sum = {32'b0, a} * {32'b0, b} + {33'b0, d[rmds_pkg::WORD_BITS-1:1]};
         if (sum[63:32] < d) begin
            res.quotient  = rmds_pkg::word_type'(sum / {32'b0, d});
            res.saturated = 1'b0;
         end
      end else if (a == '0 || b == '0) begin
         res.quotient  = '0;
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic offer_operands(rmds_pkg::word_type a, rmds_pkg::word_type b,
                                 rmds_pkg::word_type d, logic typed,
                                 result_type res);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid        = 1'b1;
      req.multiplicand = a;
      req.factor_b     = b;
      req.divisor      = d;
      row_typed        = typed;
      row_result       = res;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic offer_random_operands(int unsigned count);
      rmds_pkg::word_type a;
      rmds_pkg::word_type b;
      rmds_pkg::word_type d;
      logic [63:0]        product;
      operand_kind_type   kind;
      repeat (count) begin
         a = $urandom();
         b = $urandom();
         d = $urandom();
         kind = operand_kind_type'($urandom_range(KIND_FULL_RANGE + 2));
         if (kind > KIND_FULL_RANGE) kind = KIND_NEAR_OVERFLOW;
         case (kind)
            KIND_ZERO_DIVISOR: begin
               d = '0;
               if ($urandom_range(2) == 0) a = '0;
               if ($urandom_range(2) == 0) b = '0;
            end
            KIND_SMALL: begin
               a = $urandom_range(15);
               b = $urandom_range(15);
               d = $urandom_range(15);
            end
            KIND_NEAR_OVERFLOW: begin
               product = {32'b0, a} * {32'b0, b};
               d = product[63:32] + rmds_pkg::word_type'($urandom_range(2));
               if (d == '0) d = rmds_pkg::word_type'($urandom_range(2));
            end
            KIND_TINY_DIVISOR: begin
               a = a >> $urandom_range(31);
               b = b >> $urandom_range(31);
               d = $urandom_range(1, 2);
            end
            KIND_ROUNDING: begin
               a = $urandom_range(1000);
               b = $urandom_range(1000);
               d = $urandom_range(1, 64);
            end
            default: begin
            end
         endcase
         offer_operands(a, b, d, 1'b0, '0);
      end
   endtask

   task automatic wait_for_drain();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp.ready = 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
         end else begin
            rsp.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (req.valid && req.ready) begin
            if (row_typed) begin
               expected_results.push_back(row_result);
            end else begin
               expected_results.push_back(rounded_quotient(req.multiplicand, req.factor_b,
                                                           req.divisor));
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Unexpected response transfer: quotient %h saturated %b.",
                           rsp.quotient, rsp.saturated);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp.quotient !== want.quotient || rsp.saturated !== want.saturated) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("Mismatch: expected quotient %h saturated %b, got %h %b.",
                              want.quotient, want.saturated, rsp.quotient, rsp.saturated);
                  end
               end
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.multiplicand = '0;
      req.factor_b     = '0;
      req.divisor      = '0;
      row_typed        = 1'b0;
      row_result       = '0;
      send_idle_pct    = 28;
      recv_idle_pct    = 52;
      hold_off_cycles  = 0;
      mismatch_count   = 0;
      cycle_count      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_TABLE[i]) begin
         offer_operands(DIRECTED_TABLE[i].multiplicand, DIRECTED_TABLE[i].factor_b,
                        DIRECTED_TABLE[i].divisor, DIRECTED_TABLE[i].typed,
                        DIRECTED_TABLE[i].result);
      end
      offer_random_operands(200);
      @(negedge clock);
      req.valid = 1'b0;
      wait_for_drain();

      send_idle_pct = 52;
      recv_idle_pct = 28;
      offer_random_operands(200);

      // The response side stops for a long stretch while transfers keep coming,
      // so the pipeline fills and the request side must stall.
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      hold_off_cycles = 400;
      offer_random_operands(60);

      offer_random_operands(140);
      @(negedge clock);
      req.valid = 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
